### src/assert_macros.svh
// Shared assertion helpers for the modular exponentiation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/mexp_pkg.sv
package mexp_pkg;

  // Operand width and step counter width
  localparam int MEXP_W = 32;
  localparam int CNT_W  = $clog2(MEXP_W);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MEXP_W - 1);

  // Input request payload
  typedef struct packed {
    logic [MEXP_W-1:0] base;
    logic [MEXP_W-1:0] exponent;
  } mexp_in_t;

  // Result payload
  typedef struct packed {
    logic [MEXP_W-1:0] power;
    logic              error;
  } mexp_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             red_step;
    logic             mul_step;
    logic             sel_sq;
    logic             first;
    logic             last;
    logic             shift_e;
    logic [CNT_W-1:0] cnt;
  } mexp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic skip;
    logic e_lsb;
    logic e_upper_zero;
  } mexp_sts_t;

endpackage

### src/modular_exponentiation.sv
// Modular exponentiation, right-to-left square and multiply, bit-serial.
// A zero exponent or modulus goes straight to the done state; otherwise the
//   base is reduced, then each exponent bit up to the top set bit takes a
//   check, a modular product if set and a squaring below the top bit.
// The shared shift-and-add multiplier (one operand bit per cycle) sets the rate.
// Synchronous active-low reset: controller idles, modulus returns to 1; no stall.
module modular_exponentiation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mexp_pkg::MEXP_W-1:0] cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  mexp_pkg::mexp_in_t          in_data,
  output logic                        out_valid,
  output mexp_pkg::mexp_out_t         out_data
);

  mexp_pkg::mexp_cmd_t cmd;
  mexp_pkg::mexp_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### src/mexp_ctrl.sv
`include "assert_macros.svh"

module mexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  mexp_pkg::mexp_sts_t sts,
  output mexp_pkg::mexp_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_MULT   = 6'b001000,
    ST_SQUARE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mexp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       cnt_last;

  assign cnt_last  = (cnt_r == '0);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  // Sequence reduce, multiply and square passes
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.cnt      = cnt_r;
    cmd.first    = (cnt_r == mexp_pkg::CNT_MAX);
    cmd.last     = cnt_last;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = mexp_pkg::CNT_MAX;
          state_nxt = sts.skip ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (cnt_last) begin
          state_nxt = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_CHECK: begin
        cnt_nxt   = mexp_pkg::CNT_MAX;
        state_nxt = sts.e_lsb ? ST_MULT : ST_SQUARE;
      end
      ST_MULT: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = mexp_pkg::CNT_MAX;
          state_nxt = sts.e_upper_zero ? ST_DONE : ST_SQUARE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SQUARE: begin
        cmd.mul_step = 1'b1;
        cmd.sel_sq   = 1'b1;
        if (cnt_last) begin
          cmd.shift_e = 1'b1;
          state_nxt   = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NOW(a_step_excl, clk, rst_n, 1'b1, $onehot0({cmd.red_step, cmd.mul_step, cmd.load}))
  `ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, !busy && !out_valid)

endmodule

### src/mexp_dpath.sv
`include "assert_macros.svh"

module mexp_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mexp_pkg::MEXP_W-1:0]     cfg_data,
  input  mexp_pkg::mexp_in_t              in_data,
  input  mexp_pkg::mexp_cmd_t             cmd,
  output mexp_pkg::mexp_sts_t             sts,
  output mexp_pkg::mexp_out_t             out_data
);

  localparam int W = mexp_pkg::MEXP_W;

  logic [W-1:0] m_r, m_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] e_r, e_nxt;
  logic [W-1:0] r_r, r_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic         err_r, err_nxt;

  logic [W-1:0] acc_in;
  logic         op_bit;
  logic [W:0]   red_t;
  logic [W-1:0] red_res;
  logic [W-1:0] mul_a;
  logic [W+1:0] mul_t;
  logic [W+1:0] m_ext;
  logic [W+1:0] m2_ext;
  logic [W-1:0] mul_res;
  logic [W-1:0] step_res;
  logic         m_zero;
  logic         m_one;

  assign m_zero = (m_r == '0);
  assign m_one  = (m_r == W'(1));

  // Skip comes from the stored modulus and incoming exponent; bit tests from e_r
  assign sts.skip         = m_zero || (in_data.exponent == '0);
  assign sts.e_lsb        = e_r[0];
  assign sts.e_upper_zero = (e_r[W-1:1] == '0);

  // Shared operand bit and partial result
  assign acc_in = cmd.first ? '0 : acc_r;
  assign op_bit = b_r[cmd.cnt];

  // Reduction step: shift in one base bit, subtract modulus once
  assign red_t   = {acc_in, op_bit};
  assign red_res = (red_t >= {1'b0, m_r}) ? W'(red_t - {1'b0, m_r}) : red_t[W-1:0];

  // Multiply step: double, add multiplicand, fold back below modulus
  assign mul_a   = cmd.sel_sq ? b_r : r_r;
  assign m_ext   = {2'b00, m_r};
  assign m2_ext  = {1'b0, m_r, 1'b0};
  assign mul_t   = {1'b0, acc_in, 1'b0} + (op_bit ? {2'b00, mul_a} : '0);
  always_comb begin
    if (mul_t >= m2_ext) begin
      mul_res = W'(mul_t - m2_ext);
    end else if (mul_t >= m_ext) begin
      mul_res = W'(mul_t - m_ext);
    end else begin
      mul_res = mul_t[W-1:0];
    end
  end

  assign step_res = cmd.red_step ? red_res : mul_res;

  // Next values of the working registers
  always_comb begin
    m_nxt   = m_r;
    b_nxt   = b_r;
    e_nxt   = e_r;
    r_nxt   = r_r;
    acc_nxt = acc_r;
    err_nxt = err_r;
    if (cfg_we) begin
      m_nxt = cfg_data;
    end
    if (cmd.load) begin
      b_nxt   = in_data.base;
      e_nxt   = in_data.exponent;
      err_nxt = m_zero;
      if (m_zero) begin
        r_nxt = '0;
      end else if (in_data.exponent == '0) begin
        r_nxt = W'(1);
      end else if (m_one) begin
        r_nxt = '0;
      end else begin
        r_nxt = W'(1);
      end
    end
    if (cmd.red_step || cmd.mul_step) begin
      if (!cmd.last) begin
        acc_nxt = step_res;
      end else if (cmd.red_step || cmd.sel_sq) begin
        b_nxt = step_res;
      end else begin
        r_nxt = step_res;
      end
    end
    if (cmd.shift_e) begin
      e_nxt = e_r >> 1;
    end
  end

  // Modulus resets to one; working registers carry no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= W'(1);
    end else begin
      m_r <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r   <= b_nxt;
    e_r   <= e_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
    err_r <= err_nxt;
  end

  assign out_data.power = r_r;
  assign out_data.error = err_r;

  `ASSERT_NEXT(a_acc_below_m, clk, rst_n, (cmd.red_step || cmd.mul_step) && !cmd.last, acc_r < m_r)
  `ASSERT_NOW(a_step_mod_nz, clk, rst_n, cmd.red_step || cmd.mul_step, !m_zero)

endmodule
